@@ rtl/core/clr_pkg.sv @@
package clr_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 28;
    localparam int STEP_W   = 19;
    localparam int LEN_W    = 14;
    localparam int FRAC_W   = 16;
    localparam int IPART_W  = POS_W - FRAC_W;
    localparam int SEEN_W   = 12;

    // Datapath widths
    localparam int X_W     = FRAC_W + 2;   // signed fraction, -1.0 .. <1.0
    localparam int OPND_W  = 20;           // multiplier operand, signed
    localparam int PROD_W  = X_W + OPND_W;
    localparam int CHUNK_W = 19;           // split of the wide terms
    localparam int INNER_W = 2 * CHUNK_W;
    localparam int T_W     = 3 * CHUNK_W;
    localparam int R_W     = 40;

    localparam logic [SEEN_W-1:0]  SEEN_MAX = {SEEN_W{1'b1}};
    localparam logic [POS_W-1:0]   POS_MAX  = {POS_W{1'b1}};
    localparam logic [2:0]         OUT_CAP  = 3'd4;

    // Input word
    typedef struct packed {
        logic                line_start;
        logic [SAMPLE_W-1:0] sample;
        logic [POS_W-1:0]    start_pos;
        logic [STEP_W-1:0]   step;
        logic [LEN_W-1:0]    out_len;
    } clr_in_t;

    // Result word
    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                last;
    } clr_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_C,
        ST_MUL_IL,
        ST_MUL_IH,
        ST_MUL_T0,
        ST_MUL_T1,
        ST_MUL_T2,
        ST_EMIT
    } clr_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SETUP,
        OP_MUL_C,
        OP_MUL_IL,
        OP_MUL_IH,
        OP_MUL_T0,
        OP_MUL_T1,
        OP_MUL_T2,
        OP_EMIT
    } clr_op_t;

    typedef struct packed {
        clr_op_t op;
    } clr_cmd_t;

    typedef struct packed {
        logic pending;    // another output is due on the current window
        logic out_room;   // result register can take a word this cycle
    } clr_status_t;

endpackage

@@ rtl/core/cubic_line_resampler.sv @@
// Channel | Direction | Handshake                 | Word
// feed    | in        | feed_valid / feed_stall   | feed_word (clr_in_t)
// result  | out       | result_valid/result_stall | result_word (clr_out_t)
//
// A line-start word is loaded from idle. A sample word releases n outputs (0..4), each
// in a check, six multiply steps and an emit: one multiplier is shared over six steps.
// Reset clears the window, counters and the result register valid.
// A stalled result holds only its own register; the next output is computed
// meanwhile and waits in its emit step until the register frees up.
module cubic_line_resampler
    import clr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     feed_valid,
    output logic     feed_stall,
    input  clr_in_t  feed_word,
    output logic     result_valid,
    input  logic     result_stall,
    output clr_out_t result_word
);

    clr_cmd_t    cmd;
    clr_status_t status;

    clr_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .feed_valid      (feed_valid),
        .feed_line_start (feed_word.line_start),
        .feed_stall      (feed_stall),
        .status          (status),
        .cmd             (cmd)
    );

    clr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .feed_word    (feed_word),
        .cmd          (cmd),
        .status       (status),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_word  (result_word)
    );

    // Emit only into a free result register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EMIT |-> status.out_room)
        else $error("emit while result register full");

    // Setup only when an output is due
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_SETUP |-> status.pending)
        else $error("setup without pending output");

    // Multiply sequence starts right after setup
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_MUL_C |-> $past(cmd.op) == OP_SETUP)
        else $error("multiply sequence out of order");

    // A new result word comes only from an emit step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(cmd.op) == OP_EMIT)
        else $error("result valid without emit");

endmodule

@@ rtl/core/clr_ctrl.sv @@
module clr_ctrl
    import clr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        feed_valid,
    input  logic        feed_line_start,
    output logic        feed_stall,
    input  clr_status_t status,
    output clr_cmd_t    cmd
);

    clr_state_t state_reg;
    clr_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (feed_valid && !feed_line_start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.pending ? ST_MUL_C : ST_IDLE;
            end
            ST_MUL_C:  state_next = ST_MUL_IL;
            ST_MUL_IL: state_next = ST_MUL_IH;
            ST_MUL_IH: state_next = ST_MUL_T0;
            ST_MUL_T0: state_next = ST_MUL_T1;
            ST_MUL_T1: state_next = ST_MUL_T2;
            ST_MUL_T2: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (status.out_room)
                begin
                    state_next = ST_CHECK;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        feed_stall = 1'b1;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                feed_stall = 1'b0;
                if (feed_valid)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_CHECK:
            begin
                if (status.pending)
                begin
                    cmd.op = OP_SETUP;
                end
            end
            ST_MUL_C:  cmd.op = OP_MUL_C;
            ST_MUL_IL: cmd.op = OP_MUL_IL;
            ST_MUL_IH: cmd.op = OP_MUL_IH;
            ST_MUL_T0: cmd.op = OP_MUL_T0;
            ST_MUL_T1: cmd.op = OP_MUL_T1;
            ST_MUL_T2: cmd.op = OP_MUL_T2;
            ST_EMIT:
            begin
                if (status.out_room)
                begin
                    cmd.op = OP_EMIT;
                end
            end
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule

@@ rtl/core/clr_datapath.sv @@
module clr_datapath
    import clr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  clr_in_t     feed_word,
    input  clr_cmd_t    cmd,
    output clr_status_t status,
    input  logic        result_stall,
    output logic        result_valid,
    output clr_out_t    result_word
);

    // Line state
    logic [SAMPLE_W-1:0] win_reg [4];
    logic [SEEN_W-1:0]   seen_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [LEN_W-1:0]    left_reg;
    logic [2:0]          count_reg;
    logic                out_valid_reg;

    // Per-output working registers
    logic signed [X_W-1:0]     x_reg;
    logic signed [16:0]        a_reg;
    logic signed [19:0]        b_reg;
    logic signed [18:0]        c_reg;
    logic signed [INNER_W-1:0] inner_reg;
    logic signed [T_W-1:0]     t_reg;
    logic signed [R_W-1:0]     r_reg;
    clr_out_t                  out_reg;

    logic [IPART_W-1:0]    ipart;
    logic [IPART_W-1:0]    index;
    logic signed [X_W-1:0] x_next;
    logic [POS_W:0]        pos_sum;
    logic [POS_W-1:0]      pos_adv;

    logic signed [16:0] a_next;
    logic signed [19:0] b_next;
    logic signed [18:0] c_next;

    logic signed [OPND_W-1:0] opnd;
    logic signed [PROD_W-1:0] prod;
    logic signed [INNER_W-1:0] b_sh;
    logic signed [T_W-1:0]     a_sh;
    logic signed [R_W-1:0]     prod_r;
    logic signed [R_W-1:0]     rnd;
    logic signed [R_W:0]       y_full;
    logic [SAMPLE_W-1:0]       y_clamp;

    // Window position: index is raised to 1 below 1.0, fraction goes negative
    assign ipart = pos_reg[POS_W-1:FRAC_W];
    assign index = (ipart == '0) ? IPART_W'(1) : ipart;
    assign x_next = (ipart == '0) ? {2'b11, pos_reg[FRAC_W-1:0]}
                                  : {2'b00, pos_reg[FRAC_W-1:0]};

    assign status.pending  = (left_reg != '0) && (count_reg < OUT_CAP)
                           && (({1'b0, index} + (IPART_W + 1)'(3)) <= {1'b0, seen_reg});
    assign status.out_room = !out_valid_reg || !result_stall;

    // Saturating position advance
    assign pos_sum = {1'b0, pos_reg} + {{(POS_W + 1 - STEP_W){1'b0}}, step_reg};
    assign pos_adv = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];

    // Catmull-Rom coefficients from the window
    always_comb
    begin
        logic [19:0] p0e, p1e, p2e, p3e;
        p0e = {4'h0, win_reg[0]};
        p1e = {4'h0, win_reg[1]};
        p2e = {4'h0, win_reg[2]};
        p3e = {4'h0, win_reg[3]};
        a_next = {1'b0, win_reg[2]} - {1'b0, win_reg[0]};
        b_next = (p0e << 1) - (p1e << 2) - p1e + (p2e << 2) - p3e;
        c_next = 19'((p1e << 1) + p1e - (p2e << 1) - p2e + p3e - p0e);
    end

    // Shared multiplier operand select
    always_comb
    begin
        case (cmd.op)
            OP_MUL_C:  opnd = {c_reg[18], c_reg};
            OP_MUL_IL: opnd = {1'b0, inner_reg[CHUNK_W-1:0]};
            OP_MUL_IH: opnd = {inner_reg[INNER_W-1], inner_reg[INNER_W-1:CHUNK_W]};
            OP_MUL_T0: opnd = {1'b0, t_reg[CHUNK_W-1:0]};
            OP_MUL_T1: opnd = {1'b0, t_reg[2*CHUNK_W-1:CHUNK_W]};
            OP_MUL_T2: opnd = {t_reg[T_W-1], t_reg[T_W-1:2*CHUNK_W]};
            default:   opnd = '0;
        endcase
    end

    assign prod   = x_reg * opnd;
    assign b_sh   = {{2{b_reg[19]}}, b_reg, 16'h0000};
    assign a_sh   = {{8{a_reg[16]}}, a_reg, 32'h0000_0000};
    assign prod_r = {{(R_W - PROD_W){prod[PROD_W-1]}}, prod};

    // r holds floor(x*t / 2^38); round half up and add the center sample
    assign rnd    = (r_reg + R_W'(1024)) >>> 11;
    assign y_full = {{(R_W + 1 - SAMPLE_W){1'b0}}, win_reg[1]} + {rnd[R_W-1], rnd};

    always_comb
    begin
        if (y_full[R_W])
        begin
            y_clamp = '0;
        end
        else if (|y_full[R_W-1:SAMPLE_W])
        begin
            y_clamp = {SAMPLE_W{1'b1}};
        end
        else
        begin
            y_clamp = y_full[SAMPLE_W-1:0];
        end
    end

    // Line state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= '0;
            end
            seen_reg      <= '0;
            pos_reg       <= '0;
            step_reg      <= '0;
            left_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= (cmd.op == OP_EMIT) || (out_valid_reg && result_stall);
            if (cmd.op == OP_LOAD)
            begin
                count_reg <= '0;
                if (feed_word.line_start)
                begin
                    pos_reg  <= feed_word.start_pos;
                    step_reg <= feed_word.step;
                    left_reg <= feed_word.out_len;
                    seen_reg <= '0;
                    for (int i = 0; i < 4; i++)
                    begin
                        win_reg[i] <= '0;
                    end
                end
                else
                begin
                    win_reg[0] <= win_reg[1];
                    win_reg[1] <= win_reg[2];
                    win_reg[2] <= win_reg[3];
                    win_reg[3] <= feed_word.sample;
                    if (seen_reg != SEEN_MAX)
                    begin
                        seen_reg <= seen_reg + SEEN_W'(1);
                    end
                end
            end
            else if (cmd.op == OP_EMIT)
            begin
                left_reg  <= left_reg - LEN_W'(1);
                pos_reg   <= pos_adv;
                count_reg <= count_reg + 3'd1;
            end
        end
    end

    // Interpolation working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_SETUP:
            begin
                x_reg <= x_next;
                a_reg <= a_next;
                b_reg <= b_next;
                c_reg <= c_next;
            end
            OP_MUL_C:  inner_reg <= b_sh + prod;
            OP_MUL_IL: t_reg <= a_sh + {{(T_W - PROD_W){prod[PROD_W-1]}}, prod};
            OP_MUL_IH: t_reg <= t_reg + {prod, {CHUNK_W{1'b0}}};
            OP_MUL_T0: r_reg <= prod_r;
            OP_MUL_T1, OP_MUL_T2:
            begin
                r_reg <= (r_reg >>> CHUNK_W) + prod_r;
            end
            OP_EMIT:
            begin
                out_reg.value <= y_clamp;
                out_reg.last  <= (left_reg == LEN_W'(1));
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_reg;

endmodule
